// File: rtl/core/bounded_undo_redo_history_unit_macros.svh
`ifndef BOUNDED_UNDO_REDO_HISTORY_UNIT_MACROS_SVH
`define BOUNDED_UNDO_REDO_HISTORY_UNIT_MACROS_SVH

// same-cycle implication, sampled on aclk, off while aresetn is low
`define BURH_ASSERT_NOW(name, ante, cons) \
    name: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("history unit check failed");

// next-cycle implication, sampled on aclk, off while aresetn is low
`define BURH_ASSERT_NEXT(name, ante, cons) \
    name: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("history unit check failed");

`endif

// File: rtl/core/burh_pkg.sv
package burh_pkg;

    localparam int HISTORY_DEPTH_DEF = 64;
    localparam int TAG_BITS_DEF      = 16;
    localparam int SNAPSHOT_BITS_DEF = 32;

    localparam int KIND_W   = 2;
    localparam int TAG_W    = 16;
    localparam int SNAP_W   = 32;
    localparam int STATUS_W = 2;
    localparam int DEPTH_W  = 7;

    localparam logic [KIND_W-1:0] KIND_RECORD = 2'd0;
    localparam logic [KIND_W-1:0] KIND_UNDO   = 2'd1;
    localparam logic [KIND_W-1:0] KIND_REDO   = 2'd2;
    localparam logic [KIND_W-1:0] KIND_CLEAR  = 2'd3;

    localparam logic [STATUS_W-1:0] STAT_DONE    = 2'd0;
    localparam logic [STATUS_W-1:0] STAT_DUP     = 2'd1;
    localparam logic [STATUS_W-1:0] STAT_NO_UNDO = 2'd2;
    localparam logic [STATUS_W-1:0] STAT_NO_REDO = 2'd3;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [TAG_W-1:0]  step_tag;
        logic [SNAP_W-1:0] snapshot;
    } in_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic                step_valid;
        logic [TAG_W-1:0]    result_tag;
        logic [SNAP_W-1:0]   result_snapshot;
        logic                can_undo;
        logic                can_redo;
        logic [DEPTH_W-1:0]  undo_depth;
        logic [DEPTH_W-1:0]  redo_depth;
    } out_t;

    // at most one of these per ring per item
    typedef struct packed {
        logic push;
        logic pop;
        logic empty;
    } ring_op_t;

endpackage

// File: rtl/core/burh_ram.sv
module burh_ram
    import burh_pkg::*;
#(
    parameter int WIDTH = TAG_BITS_DEF + SNAPSHOT_BITS_DEF,
    parameter int DEPTH = HISTORY_DEPTH_DEF
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// File: rtl/core/burh_ring.sv
module burh_ring
    import burh_pkg::*;
#(
    parameter int DEPTH = HISTORY_DEPTH_DEF
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  ring_op_t                   op,
    output logic [$clog2(DEPTH)-1:0]   top_slot,
    output logic [$clog2(DEPTH)-1:0]   below_slot,
    output logic [$clog2(DEPTH)-1:0]   push_slot,
    output logic [$clog2(DEPTH+1)-1:0] count,
    output logic [$clog2(DEPTH+1)-1:0] count_next
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int SW = CW + 1;

    logic [AW-1:0] oldest_reg, oldest_next;
    logic [CW-1:0] count_reg, count_next_w;

    // operand is always below twice the depth, so one subtract wraps it
    function automatic logic [AW-1:0] wrap(input logic [SW-1:0] x);
        logic [SW-1:0] d;
        d = SW'(DEPTH);
        return (x >= d) ? AW'(x - d) : AW'(x);
    endfunction

    always_comb begin
        top_slot   = (count_reg == '0) ? '0
                   : wrap(SW'(oldest_reg) + SW'(count_reg) - SW'(1));
        below_slot = (count_reg < CW'(2)) ? '0
                   : wrap(SW'(oldest_reg) + SW'(count_reg) - SW'(2));
        push_slot  = wrap(SW'(oldest_reg) + SW'(count_reg));
    end

    always_comb begin
        oldest_next  = oldest_reg;
        count_next_w = count_reg;
        if (op.empty) begin
            oldest_next  = '0;
            count_next_w = '0;
        end else if (op.push) begin
            // a full ring drops its oldest entry, the count stays put
            if (count_reg == CW'(DEPTH)) begin
                oldest_next = wrap(SW'(oldest_reg) + SW'(1));
            end else begin
                count_next_w = count_reg + CW'(1);
            end
        end else if (op.pop) begin
            count_next_w = count_reg - CW'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            oldest_reg <= '0;
            count_reg  <= '0;
        end else begin
            oldest_reg <= oldest_next;
            count_reg  <= count_next_w;
        end
    end

    assign count      = count_reg;
    assign count_next = count_next_w;

endmodule

// File: rtl/core/bounded_undo_redo_history_unit.sv
// channel  ports                       direction  payload
// input    s_valid s_ready s_data      in         in_t  (kind, step_tag, snapshot)
// result   m_valid m_ready m_data      out        out_t (status, step, flags, depths)
//
// record, redo, clear and refused undo: result registered in the EXEC step
// successful undo: via UNDO_FIN, as it reads undo memory at the old top and the one below
// single undo read port; a new item is taken in idle only, once the last result is loaded
// reset clears state, m_valid, ring pointers, counts; memories are not cleared, no sweep
// a stalled result holds the final step; the next transfer is taken once back in idle
`include "bounded_undo_redo_history_unit_macros.svh"

module bounded_undo_redo_history_unit
    import burh_pkg::*;
#(
    parameter int HISTORY_DEPTH = HISTORY_DEPTH_DEF,
    parameter int TAG_BITS      = TAG_BITS_DEF,
    parameter int SNAPSHOT_BITS = SNAPSHOT_BITS_DEF
) (
    input  logic aclk,
    input  logic aresetn,
    input  logic s_valid,
    output logic s_ready,
    input  in_t  s_data,
    output logic m_valid,
    input  logic m_ready,
    output out_t m_data
);

    localparam int AW = $clog2(HISTORY_DEPTH);
    localparam int CW = $clog2(HISTORY_DEPTH + 1);
    localparam int EW = TAG_BITS + SNAPSHOT_BITS;

    localparam logic [1:0] ST_IDLE     = 2'd0;
    localparam logic [1:0] ST_EXEC     = 2'd1;
    localparam logic [1:0] ST_UNDO_FIN = 2'd2;

    logic [1:0] state_reg, state_next;
    in_t        item_reg;
    logic       m_valid_reg, m_valid_next;
    out_t       m_data_reg, m_data_next;

    ring_op_t      u_op, r_op;
    logic [AW-1:0] u_top, u_below, u_push, r_top, r_push;
    logic [CW-1:0] u_cnt, u_cnt_next, r_cnt, r_cnt_next;

    logic          u_we, r_we, u_re, r_re;
    logic [AW-1:0] u_wa, r_wa, u_ra;
    logic [EW-1:0] u_wd, r_wd, u_rd, r_rd;

    logic          accept, out_free, out_load, undo_ok, redo_ok, dup;
    logic [EW-1:0] res_entry;
    logic          res_valid;
    logic [STATUS_W-1:0] res_status;

    burh_ring #(.DEPTH(HISTORY_DEPTH)) u_undo_ring (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .op         (u_op),
        .top_slot   (u_top),
        .below_slot (u_below),
        .push_slot  (u_push),
        .count      (u_cnt),
        .count_next (u_cnt_next)
    );

    burh_ring #(.DEPTH(HISTORY_DEPTH)) u_redo_ring (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .op         (r_op),
        .top_slot   (r_top),
        .below_slot (),
        .push_slot  (r_push),
        .count      (r_cnt),
        .count_next (r_cnt_next)
    );

    burh_ram #(.WIDTH(EW), .DEPTH(HISTORY_DEPTH)) u_undo_mem (
        .aclk    (aclk),
        .wr_en   (u_we),
        .wr_addr (u_wa),
        .wr_data (u_wd),
        .rd_en   (u_re),
        .rd_addr (u_ra),
        .rd_data (u_rd)
    );

    burh_ram #(.WIDTH(EW), .DEPTH(HISTORY_DEPTH)) u_redo_mem (
        .aclk    (aclk),
        .wr_en   (r_we),
        .wr_addr (r_wa),
        .wr_data (r_wd),
        .rd_en   (r_re),
        .rd_addr (r_top),
        .rd_data (r_rd)
    );

    assign s_ready  = (state_reg == ST_IDLE);
    assign accept   = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;
    assign undo_ok  = (u_cnt >= CW'(2));
    assign redo_ok  = (r_cnt != '0);
    assign dup      = (u_cnt != '0)
                   && (u_rd[SNAPSHOT_BITS-1:0] == SNAPSHOT_BITS'(item_reg.snapshot));

    // tops are read in the transfer cycle; writes only land in the EXEC step,
    // never in idle, so a read never meets a pending write to the same entry
    always_comb begin
        u_re = accept;
        u_ra = u_top;
        r_re = accept;
        if (state_reg == ST_EXEC && item_reg.kind == KIND_UNDO && undo_ok) begin
            u_re = 1'b1;
            u_ra = u_below;
        end
    end

    always_comb begin
        state_next = state_reg;
        u_op       = '0;
        r_op       = '0;
        u_we       = 1'b0;
        u_wa       = u_push;
        u_wd       = {TAG_BITS'(item_reg.step_tag), SNAPSHOT_BITS'(item_reg.snapshot)};
        r_we       = 1'b0;
        r_wa       = r_push;
        r_wd       = u_rd;
        out_load   = 1'b0;
        res_entry  = '0;
        res_valid  = 1'b0;
        res_status = STAT_DONE;

        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC: begin
                unique case (item_reg.kind)
                    KIND_RECORD: begin
                        if (out_free) begin
                            out_load   = 1'b1;
                            state_next = ST_IDLE;
                            if (dup) begin
                                res_status = STAT_DUP;
                            end else begin
                                u_op.push  = 1'b1;
                                r_op.empty = 1'b1;
                                u_we       = 1'b1;
                            end
                        end
                    end
                    KIND_UNDO: begin
                        if (undo_ok) begin
                            // popped top moves to redo, new top read meanwhile
                            u_op.pop   = 1'b1;
                            r_op.push  = 1'b1;
                            r_we       = 1'b1;
                            state_next = ST_UNDO_FIN;
                        end else if (out_free) begin
                            res_status = STAT_NO_UNDO;
                            out_load   = 1'b1;
                            state_next = ST_IDLE;
                        end
                    end
                    KIND_REDO: begin
                        if (out_free) begin
                            out_load   = 1'b1;
                            state_next = ST_IDLE;
                            if (redo_ok) begin
                                r_op.pop  = 1'b1;
                                u_op.push = 1'b1;
                                u_we      = 1'b1;
                                u_wd      = r_rd;
                                res_entry = r_rd;
                                res_valid = 1'b1;
                            end else begin
                                res_status = STAT_NO_REDO;
                            end
                        end
                    end
                    KIND_CLEAR: begin
                        if (out_free) begin
                            u_op.empty = 1'b1;
                            r_op.empty = 1'b1;
                            out_load   = 1'b1;
                            state_next = ST_IDLE;
                        end
                    end
                    default: ;
                endcase
            end
            ST_UNDO_FIN: begin
                if (out_free) begin
                    res_entry  = u_rd;
                    res_valid  = 1'b1;
                    out_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        m_data_next                 = m_data_reg;
        m_valid_next                = m_valid_reg && !m_ready;
        if (out_load) begin
            m_valid_next                = 1'b1;
            m_data_next.status          = res_status;
            m_data_next.step_valid      = res_valid;
            m_data_next.result_tag      = TAG_W'(res_entry[EW-1:SNAPSHOT_BITS]);
            m_data_next.result_snapshot = SNAP_W'(res_entry[SNAPSHOT_BITS-1:0]);
            m_data_next.can_undo        = (u_cnt_next > CW'(1));
            m_data_next.can_redo        = (r_cnt_next != '0);
            m_data_next.undo_depth      = DEPTH_W'(u_cnt_next);
            m_data_next.redo_depth      = DEPTH_W'(r_cnt_next);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            item_reg <= s_data;
        end
        m_data_reg <= m_data_next;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    `BURH_ASSERT_NEXT(a_transfer_leaves_idle, s_valid && s_ready, state_reg != ST_IDLE)
    `BURH_ASSERT_NOW(a_undo_count_bounded, 1'b1, u_cnt <= CW'(HISTORY_DEPTH))
    `BURH_ASSERT_NOW(a_ring_ops_exclusive, 1'b1, $onehot0(u_op) && $onehot0(r_op))
    `BURH_ASSERT_NOW(a_step_only_when_done, m_valid && m_data.step_valid,
                     m_data.status == STAT_DONE)

endmodule
